// ===== hdl/segmented_prime_sieve_top_assert.svh =====
// assertion macros for the segmented prime sieve checker
`ifndef SEGMENTED_PRIME_SIEVE_TOP_ASSERT_SVH
`define SEGMENTED_PRIME_SIEVE_TOP_ASSERT_SVH
// property checked in the same cycle
`define SPS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// property checked in the cycle after the antecedent
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/sps_pkg.sv =====
// shared constants and types of the segmented prime sieve
package sps_pkg;
	localparam int VALUE_BITS = 40;
	localparam int SEG_BITS   = 4096;
	localparam int WORD_BITS  = 64;
	localparam int WORD_COUNT = SEG_BITS / WORD_BITS;
	localparam int ADDR_W     = $clog2(WORD_COUNT);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int OFF_W      = $clog2(SEG_BITS);
	localparam int PRIME_W    = 20;
	localparam int STEP_W     = PRIME_W + 1;
	localparam int FUNC_W     = 2;
	localparam int CNT_W      = $clog2(VALUE_BITS);

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
	localparam logic [VALUE_BITS-1:0] UL_RESET  = VALUE_BITS'(64'd1000000000);
	localparam logic [VALUE_BITS-1:0] SEG_SPAN  = VALUE_BITS'(SEG_BITS - 1);
	localparam logic [VALUE_BITS-1:0] MIN_START = VALUE_BITS'(2);

	// operation codes of the func field
	localparam logic [FUNC_W-1:0] FN_START  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_STRIKE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_START_SAT,
		ST_START_CLAMP,
		ST_START_SET,
		ST_DIV,
		ST_FIRST,
		ST_CLIP,
		ST_OFF,
		ST_WALK_RD,
		ST_WALK_LD,
		ST_WALK_MK,
		ST_WALK_WB,
		ST_READ_RD,
		ST_READ_DT,
		ST_DONE
	} state_t;
endpackage

// ===== hdl/sps_req_if.sv =====
// input channel of the sieve: one operation per transaction
interface sps_req_if import sps_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [FUNC_W-1:0]     func;
	logic [VALUE_BITS-1:0] seg_start;
	logic [PRIME_W-1:0]    base_prime;
	logic [ADDR_W-1:0]     word_index;

	modport source (output valid, func, seg_start, base_prime, word_index, input ready);
	modport sink (input valid, func, seg_start, base_prime, word_index, output ready);
endinterface

// ===== hdl/sps_rsp_if.sv =====
// result channel of the sieve
interface sps_rsp_if import sps_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] prime_mask;
	logic [FUNC_W-1:0]    done_func;

	modport source (output valid, prime_mask, done_func, input ready);
	modport sink (input valid, prime_mask, done_func, output ready);
endinterface

// ===== hdl/sps_cfg_if.sv =====
// configuration write channel carrying the upper limit
interface sps_cfg_if import sps_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] upper_limit;

	modport source (output valid, upper_limit, input ready);
	modport sink (input valid, upper_limit, output ready);
endinterface

// ===== hdl/segmented_prime_sieve_top.sv =====
// top level of the segmented prime sieve engine
// One operation per transaction on req (func, seg_start, base_prime, word_index);
// funcs start, strike and read each return one transaction on rsp (prime_mask,
// done_func), func 3 is consumed silently. cfg writes upper_limit and is always
// ready; write it only while the engine is idle.
// Operations run one at a time; req is ready only in the idle state.
// Steps from acceptance to result in the output register:
//   start  bound saturation, clamp, bitmap row invalidate
//   read   one bitmap memory read
//   strike straight to the result for p below two or no valid segment;
//          otherwise the bit-serial remainder of segment_low by p and the
//          bound checks, then per bitmap word touched a read, a mark for
//          each value struck in it and a write-back of the word
// The result sits in an output register; a new operation is accepted while
// it waits, and a finished result waits for the register to drain.
// Reset clears the segment (invalid), the row valid bits and loads the reset
// upper limit; no clearing pass is needed since each row has a valid bit.
module segmented_prime_sieve_top import sps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sps_req_if.sink     req,
	sps_rsp_if.source   rsp,
	sps_cfg_if.sink     cfg
);
	state_t state_q, state_d;

	// latched operation
	logic [FUNC_W-1:0]     func_q;
	logic [VALUE_BITS-1:0] start_q;
	logic [PRIME_W-1:0]    prime_q;
	logic [ADDR_W-1:0]     word_q;

	// configuration and segment bounds
	logic [VALUE_BITS-1:0] ul_q;
	logic [VALUE_BITS-1:0] seg_low_q;
	logic [OFF_W-1:0]      seg_span_q;
	logic                  seg_valid_q;
	logic [VALUE_BITS-1:0] end_q;

	// strike datapath
	logic [VALUE_BITS-1:0] sq_q;
	logic [VALUE_BITS-1:0] first_q;
	logic [STEP_W-1:0]     off_q;
	logic [ADDR_W-1:0]     wcur_q;
	logic [WORD_BITS-1:0]  wd_q;
	logic [WORD_BITS-1:0]  mask_q;

	// per-row valid bits stand in for clearing the bitmap
	logic [WORD_COUNT-1:0] row_vld_q;

	// output register
	logic                  rsp_vld_q;
	logic [WORD_BITS-1:0]  rsp_mask_q;
	logic [FUNC_W-1:0]     rsp_func_q;

	// remainder unit
	logic                  div_start;
	logic                  div_done;
	logic [PRIME_W-1:0]    div_rem;

	// bitmap memory
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_raddr;
	logic [WORD_BITS-1:0]  mem_rdata;
	logic [WORD_BITS-1:0]  row_word;

	// combinational helpers
	logic                  req_fire;
	logic                  out_free;
	logic [VALUE_BITS:0]   sat_sum;
	logic [VALUE_BITS:0]   first_sum;
	logic [PRIME_W-1:0]    gap;
	logic [VALUE_BITS-1:0] off_diff;
	logic                  off_beyond;
	logic [STEP_W-1:0]     off_nxt;
	logic                  nxt_beyond;
	logic                  nxt_leaves;
	logic                  cur_beyond;
	logic [OFF_W:0]        read_lim;
	logic [WORD_BITS-1:0]  range_mask;
	logic [VALUE_BITS-1:0] clamp_end;
	logic [2*PRIME_W-1:0]  sq_prod;

	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_vld_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid      = rsp_vld_q;
	assign rsp.prime_mask = rsp_mask_q;
	assign rsp.done_func  = rsp_func_q;

	// segment end before the limit clamp, saturated at the value range
	assign sat_sum   = {1'b0, start_q} + {1'b0, SEG_SPAN};
	assign clamp_end = (end_q > ul_q) ? ul_q : end_q;

	// p squared; the upper operand halves are zero, a 20 by 20 bit product
	assign sq_prod = {{PRIME_W{1'b0}}, prime_q} * {{PRIME_W{1'b0}}, prime_q};

	// first multiple of p at or above segment_low
	assign gap       = (div_rem == '0) ? '0 : (prime_q - div_rem);
	assign first_sum = {1'b0, seg_low_q} + {{(VALUE_BITS-PRIME_W+1){1'b0}}, gap};

	// offset of the first mark inside the segment
	assign off_diff   = first_q - seg_low_q;
	assign off_beyond = (off_diff[VALUE_BITS-1:OFF_W] != '0) ||
		(off_diff[OFF_W-1:0] > seg_span_q);

	// stepping through the bitmap
	assign off_nxt    = off_q + {1'b0, prime_q};
	assign nxt_beyond = (off_nxt[STEP_W-1:OFF_W] != '0) ||
		(off_nxt[OFF_W-1:0] > seg_span_q);
	assign nxt_leaves = (off_nxt[STEP_W-1:BIT_W] != {{(STEP_W-OFF_W){1'b0}}, wcur_q});
	assign cur_beyond = (off_q[STEP_W-1:OFF_W] != '0) ||
		(off_q[OFF_W-1:0] > seg_span_q);

	// bits of a read word that lie inside the segment
	assign read_lim = {1'b0, seg_span_q} - {1'b0, word_q, {BIT_W{1'b0}}};
	always_comb begin
		if (read_lim[OFF_W]) begin
			range_mask = '0;
		end else if (read_lim[OFF_W-1:BIT_W] != '0) begin
			range_mask = '1;
		end else begin
			range_mask = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - read_lim[BIT_W-1:0]);
		end
	end

	// a row never written since the last start reads as all clear
	assign row_word = row_vld_q[wcur_q] ? mem_rdata : '0;

	sps_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (seg_low_q),
		.divisor   (prime_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	sps_ram #(
		.DEPTH (WORD_COUNT),
		.WIDTH (WORD_BITS)
	) u_bitmap (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wcur_q),
		.wdata (wd_q),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = off_q[OFF_W-1:BIT_W];
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				case (func_q)
					FN_START:  state_d = ST_START_SAT;
					FN_STRIKE: begin
						if (prime_q < PRIME_W'(2) || !seg_valid_q) begin
							state_d = ST_DONE;
						end else begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end
					end
					FN_READ:   state_d = ST_READ_RD;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_START_SAT:   state_d = ST_START_CLAMP;
			ST_START_CLAMP: state_d = ST_START_SET;
			ST_START_SET:   state_d = ST_DONE;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FIRST;
				end
			end
			ST_FIRST: begin
				state_d = first_sum[VALUE_BITS] ? ST_DONE : ST_CLIP;
			end
			ST_CLIP: state_d = ST_OFF;
			ST_OFF: begin
				state_d = off_beyond ? ST_DONE : ST_WALK_RD;
			end
			ST_WALK_RD: state_d = ST_WALK_LD;
			ST_WALK_LD: state_d = ST_WALK_MK;
			ST_WALK_MK: begin
				if (nxt_beyond || nxt_leaves) begin
					state_d = ST_WALK_WB;
				end
			end
			ST_WALK_WB: begin
				mem_we  = 1'b1;
				state_d = cur_beyond ? ST_DONE : ST_WALK_RD;
			end
			ST_READ_RD: begin
				mem_raddr = word_q;
				state_d   = seg_valid_q ? ST_READ_DT : ST_DONE;
			end
			ST_READ_DT: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ul_q        <= UL_RESET;
			seg_valid_q <= 1'b0;
			row_vld_q   <= '0;
			rsp_vld_q   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				ul_q <= cfg.upper_limit;
			end
			if (state_q == ST_START_SET) begin
				seg_valid_q <= (end_q >= start_q);
				row_vld_q   <= '0;
			end
			if (state_q == ST_WALK_WB) begin
				row_vld_q[wcur_q] <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					func_q  <= req.func;
					// starts below two are raised to two
					start_q <= (req.seg_start < MIN_START) ? MIN_START : req.seg_start;
					prime_q <= req.base_prime;
					word_q  <= req.word_index;
				end
			end
			ST_DISP: begin
				mask_q <= '0;
				sq_q   <= VALUE_BITS'(sq_prod);
			end
			ST_START_SAT: begin
				end_q <= sat_sum[VALUE_BITS] ? VALUE_MAX : sat_sum[VALUE_BITS-1:0];
			end
			ST_START_CLAMP: begin
				end_q <= clamp_end;
			end
			ST_START_SET: begin
				seg_low_q  <= start_q;
				seg_span_q <= OFF_W'(end_q - start_q);
			end
			ST_FIRST: begin
				first_q <= first_sum[VALUE_BITS-1:0];
			end
			ST_CLIP: begin
				// marks begin no lower than p squared
				if (sq_q > first_q) begin
					first_q <= sq_q;
				end
			end
			ST_OFF: begin
				off_q <= {{(STEP_W-OFF_W){1'b0}}, off_diff[OFF_W-1:0]};
			end
			ST_WALK_RD: begin
				wcur_q <= off_q[OFF_W-1:BIT_W];
			end
			ST_WALK_LD: begin
				wd_q <= row_word;
			end
			ST_WALK_MK: begin
				wd_q[off_q[BIT_W-1:0]] <= 1'b1;
				off_q <= off_nxt;
			end
			ST_READ_RD: begin
				wcur_q <= word_q;
			end
			ST_READ_DT: begin
				mask_q <= ~row_word & range_mask;
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			rsp_mask_q <= mask_q;
			rsp_func_q <= func_q;
		end
	end
endmodule

// ===== hdl/sps_rem.sv =====
// iterative remainder unit, one dividend bit per cycle
module sps_rem import sps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [PRIME_W-1:0]    divisor,
	output logic                  done,
	output logic [PRIME_W-1:0]    remainder
);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(VALUE_BITS - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] dvd_q;
	logic [PRIME_W-1:0]    dvs_q;
	logic [PRIME_W-1:0]    rem_q;
	logic [PRIME_W:0]      shifted;
	logic [PRIME_W:0]      diff;

	assign shifted = {rem_q, dvd_q[VALUE_BITS-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_BITS-2:0], 1'b0};
			// remainder stays below the divisor, so the low bits suffice
			if (shifted >= {1'b0, dvs_q}) begin
				rem_q <= diff[PRIME_W-1:0];
			end else begin
				rem_q <= shifted[PRIME_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
endmodule

// ===== hdl/sps_ram.sv =====
// single-port-write, registered-read memory
module sps_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/sps_checker.sv =====
// port-level checker for the segmented prime sieve, bound to the top level
module sps_checker import sps_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [WORD_BITS-1:0] rsp_mask,
	input logic [FUNC_W-1:0]    rsp_func
);
`include "segmented_prime_sieve_top_assert.svh"

	// unused func never produces a result
	`SPS_ASSERT_SAME(a_no_unused_result, rsp_valid, rsp_func != FN_UNUSED, "result for unused func")
	// only reads carry a nonzero mask
	`SPS_ASSERT_SAME(a_mask_only_read, rsp_valid && rsp_func != FN_READ, rsp_mask == '0, "mask on non-read")
	// one operation at a time
	`SPS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "accepted while busy")
	// stalled result holds
	`SPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_mask) && $stable(rsp_func), "stalled result changed")
endmodule

bind segmented_prime_sieve_top sps_checker u_sps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_mask  (rsp.prime_mask),
	.rsp_func  (rsp.done_func)
);
